/* hw/rtl/cfd_pkg.sv */
// Package for the checksummed frame deframer.
// Holds the frame geometry, field widths and sync byte that the RTL files share.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  // Window and frame geometry.
  localparam int unsigned FrameLen = 70;
  localparam int unsigned PosW     = $clog2(FrameLen);

  // Payload widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned ValW  = 16;

  // Default channel count per frame.
  localparam int unsigned DefChannels = 34;

  localparam logic [ByteW-1:0] SyncByte = 8'h00;

endpackage : cfd_pkg

`default_nettype wire

/* hw/rtl/cfd_in_if.sv */
// Input channel of the deframer: one received serial byte per request.
// Depends on cfd_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : cfd_in_if

`default_nettype wire

/* hw/rtl/cfd_out_if.sv */
// Output channel of the deframer: one decoded channel value per request.
// Depends on cfd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_out_if;
  logic                      valid;
  logic                      ready;
  logic [cfd_pkg::IdxW-1:0]  channel_index;
  logic [cfd_pkg::ValW-1:0]  channel_value;
  logic                      last_of_frame;

  modport source (output valid, output channel_index, output channel_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_of_frame, output ready);
endinterface : cfd_out_if

`default_nettype wire

/* hw/rtl/cfd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 70,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : cfd_ram

`default_nettype wire

/* hw/rtl/checksummed_frame_deframer.sv */
// Checksummed frame deframer top level.
// Uses cfd_pkg, cfd_in_if, cfd_out_if and cfd_ram (the 70-byte window store).
//
// Usage: rx_i carries one received byte per request. The block keeps the last
// 70 bytes in a circular window RAM and a running 8-bit sum of its contents.
// While the window is not yet full a byte is taken every cycle. The oldest
// byte is read from the RAM as each byte is taken; after the byte that fills
// the window, StCheck checks it against the sync byte and the sum against
// twice the newest byte. A failed check drops the oldest byte and the block
// takes input again. A good frame is read back two bytes per channel through
// StLo, StHi and StOut; res_o delivers CHANNELS values, the last marked with
// last_of_frame, and no input is taken during that burst. The output rate is
// bounded by the single read port of the window RAM. The result sits in an
// output register, so the next input byte is taken while the final value
// still waits. If the receiver stalls, the burst waits on the output register
// with nothing lost. Reset empties the window and clears the sum; the RAM
// contents are not cleared, as only written entries are used.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_deframer #(
  parameter int unsigned CHANNELS = cfd_pkg::DefChannels
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfd_in_if.sink      rx_i,
  cfd_out_if.source   res_o
);

  localparam int unsigned PosW  = cfd_pkg::PosW;
  localparam int unsigned ByteW = cfd_pkg::ByteW;
  localparam int unsigned IdxW  = cfd_pkg::IdxW;

  localparam logic [PosW-1:0] LastPos  = PosW'(cfd_pkg::FrameLen - 1);
  localparam logic [PosW-1:0] FullFill = PosW'(cfd_pkg::FrameLen - 1);
  localparam logic [IdxW-1:0] LastCh   = IdxW'(CHANNELS - 1);
  localparam logic [PosW:0]   FrameLenW = (PosW+1)'(cfd_pkg::FrameLen);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StLo    = 3'd2;
  localparam logic [2:0] StHi    = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [PosW-1:0]  fill_q, fill_d;
  logic [PosW-1:0]  oldest_q, oldest_d;
  logic [PosW-1:0]  ptr_q, ptr_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] newest_q, newest_d;
  logic [ByteW-1:0] lo_q, lo_d;
  logic [IdxW-1:0]  ch_q, ch_d;

  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic [cfd_pkg::ValW-1:0] out_val_q, out_val_d;
  logic             out_last_q, out_last_d;

  logic             rx_accept;
  logic             out_free;
  logic [PosW:0]    wr_sum;
  logic [PosW-1:0]  wr_addr;
  logic             ram_re;
  logic [PosW-1:0]  ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  logic [ByteW-1:0] twice_newest;
  logic             frame_good;

  function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] p);
    pos_inc = (p == LastPos) ? '0 : p + PosW'(1);
  endfunction

  assign rx_i.ready = (state_q == StIdle);
  assign rx_accept  = rx_i.valid && rx_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;

  // Position of the new byte: (oldest + fill) mod 70, both below 70.
  assign wr_sum  = {1'b0, oldest_q} + {1'b0, fill_q};
  assign wr_addr = (wr_sum >= FrameLenW) ? PosW'(wr_sum - FrameLenW) : wr_sum[PosW-1:0];

  // The sum of the first 69 bytes equals the whole-window sum minus the newest
  // byte, so the checksum holds when the window sum is twice the newest byte.
  assign twice_newest = {newest_q[ByteW-2:0], 1'b0};
  assign frame_good   = (ram_rdata == cfd_pkg::SyncByte) && (sum_q == twice_newest);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = oldest_q;
    unique case (state_q)
      StIdle: begin
        ram_re    = rx_accept;
        ram_raddr = oldest_q;
      end
      StLo, StHi: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = oldest_q;
      end
    endcase
  end

  cfd_ram #(
    .Width (ByteW),
    .Depth (cfd_pkg::FrameLen)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (rx_accept),
    .waddr_i (wr_addr),
    .wdata_i (rx_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    ptr_d       = ptr_q;
    sum_d       = sum_q;
    newest_d    = newest_q;
    lo_d        = lo_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (rx_accept) begin
          newest_d = rx_i.rx_byte;
          sum_d    = sum_q + rx_i.rx_byte;
          if (fill_q == FullFill) begin
            state_d = StCheck;
          end else begin
            fill_d = fill_q + PosW'(1);
          end
        end
      end
      StCheck: begin
        if (frame_good) begin
          ptr_d   = pos_inc(oldest_q);
          ch_d    = '0;
          state_d = StLo;
        end else begin
          // Drop the oldest byte; the window stays one byte short of full.
          sum_d    = sum_q - ram_rdata;
          oldest_d = pos_inc(oldest_q);
          state_d  = StIdle;
        end
      end
      StLo: begin
        ptr_d   = pos_inc(ptr_q);
        state_d = StHi;
      end
      StHi: begin
        ptr_d   = pos_inc(ptr_q);
        lo_d    = ram_rdata;
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = ch_q;
          out_val_d   = {ram_rdata, lo_q};
          out_last_d  = (ch_q == LastCh);
          ch_d        = ch_q + IdxW'(1);
          if (ch_q == LastCh) begin
            fill_d   = '0;
            oldest_d = '0;
            sum_d    = '0;
            state_d  = StIdle;
          end else begin
            state_d = StLo;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      oldest_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    newest_q   <= newest_d;
    lo_q       <= lo_d;
    ch_q       <= ch_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.channel_index = out_idx_q;
  assign res_o.channel_value = out_val_q;
  assign res_o.last_of_frame = out_last_q;

endmodule : checksummed_frame_deframer

`default_nettype wire
